// ===== rtl/core/stack_machine_execute_unit_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define SMEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SMEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/core/smeu_pkg.sv =====
// package for the stack machine execute unit: opcodes, error codes, sizes, states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package smeu_pkg;
  localparam int STACK_DEPTH_DEF  = 128;
  localparam int PROGRAM_SIZE_DEF = 1024;
  localparam int WORD_WIDTH_DEF   = 32;
  localparam int KIND_W = 5;
  localparam int OPND_W = 32;
  localparam int PC_W   = 10;
  localparam int ERR_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_LABEL = 5'd0, OP_LOAD = 5'd1, OP_LOADI = 5'd2, OP_STO = 5'd3, OP_STI = 5'd4,
    OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MULT = 5'd7, OP_DIV = 5'd8, OP_BR = 5'd9,
    OP_BRF = 5'd10, OP_EQ = 5'd11, OP_NOTEQ = 5'd12, OP_GT = 5'd13, OP_LES = 5'd14,
    OP_GE = 5'd15, OP_LE = 5'd16, OP_AND = 5'd17, OP_OR = 5'd18, OP_NOT = 5'd19,
    OP_IN = 5'd20, OP_OUT = 5'd21, OP_RETURN = 5'd22, OP_ENTER = 5'd23,
    OP_CAL = 5'd24, OP_STOP = 5'd25
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0, ERR_STACK = 2'd1, ERR_DIV0 = 2'd2, ERR_ADDR = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_RD2, ST_OPND, ST_DIV, ST_EXEC, ST_WR2, ST_RSLT
  } exec_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/smeu_ram.sv =====
// generic single-port-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/smeu_front.sv =====
// front end: accepts instructions into a two-entry queue
// depends on smeu_pkg
`timescale 1ns / 1ps
`default_nettype none
module smeu_front
  import smeu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [71:0]       s_tdata,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output logic [KIND_W-1:0]      q_kind,
  output logic [OPND_W-1:0]      q_operand,
  output logic [OPND_W-1:0]      q_in_value
);
  localparam int ENT_W = KIND_W + 2 * OPND_W;
  logic [ENT_W-1:0] slot [2];
  logic             rd_ptr, wr_ptr;
  logic [1:0]       count;
  logic             push;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign {q_in_value, q_operand, q_kind} = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {s_tdata[68:37], s_tdata[36:5], s_tdata[4:0]};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/smeu_divider.sv =====
// radix-2 restoring divider for signed words, truncating toward zero
// depends on smeu_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none
module smeu_divider
  import smeu_pkg::*;
#(
  parameter int WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient
);
  localparam int CNT_W = $clog2(WIDTH + 1);
  logic [WIDTH-1:0] rem, quo, dvs;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  assign shifted  = {rem, quo[WIDTH-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  // one quotient bit per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
        rem  <= '0;
        quo  <= dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
        dvs  <= divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
        neg  <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
      end else if (busy) begin
        if (!trial[WIDTH]) begin
          rem <= trial[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= shifted[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/smeu_back.sv =====
// back end: executes one instruction against the stack ram, drives results
// depends on smeu_pkg, smeu_ram, smeu_divider
`timescale 1ns / 1ps
`default_nettype none
module smeu_back
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int PROGRAM_SIZE = PROGRAM_SIZE_DEF,
  parameter int WORD_WIDTH   = WORD_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [KIND_W-1:0] q_kind,
  input  wire logic [OPND_W-1:0] q_operand,
  input  wire logic [OPND_W-1:0] q_in_value,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [47:0]            m_tdata
);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int TW  = AW + 1;
  localparam int PCW = $clog2(PROGRAM_SIZE);
  localparam int EW  = 34;  // wide signed for address math

  exec_state_t st, st_next;

  // architectural state
  logic [TW-1:0]  top;
  logic [AW-1:0]  base;
  logic [PCW-1:0] pc;
  logic           halt;
  // valid bits for stack entries (reset value zero)
  logic [STACK_DEPTH-1:0] vld;
  // latched instruction and operands
  opcode_t             k;
  logic [OPND_W-1:0]   opnd, inv;
  logic [WORD_WIDTH-1:0] a, b;
  logic [WORD_WIDTH-1:0] prod;
  logic [PCW-1:0]      seq_l;
  // result register
  logic                r_full;
  logic [47:0]         r_data;

  // ram ports
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [WORD_WIDTH-1:0] wdata, rdata, rword;
  smeu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  logic rd_vld;
  always_ff @(posedge clk) rd_vld <= vld[raddr];
  assign rword = rd_vld ? rdata : '0;

  // divider, started while the second word leaves the ram
  logic div_start, div_done;
  logic [WORD_WIDTH-1:0] div_q;
  smeu_divider #(.WIDTH(WORD_WIDTH)) u_div (
    .clk, .rst, .start(div_start), .dividend(a), .divisor(rword),
    .done(div_done), .quotient(div_q)
  );

  // derived quantities
  logic signed [EW-1:0] op_s, addr_s, ntop_s;
  logic [PCW-1:0] seq;
  logic addr_ok, tgt_ok, is_bin;
  assign op_s    = EW'($signed(opnd));
  assign addr_s  = $signed({{(EW-AW){1'b0}}, base}) + op_s;
  assign ntop_s  = $signed({{(EW-TW){1'b0}}, top}) + op_s;
  assign addr_ok = (addr_s >= 0) && (addr_s < EW'(STACK_DEPTH));
  assign tgt_ok  = (op_s >= 0) && (op_s < EW'(PROGRAM_SIZE));
  assign seq     = (32'(pc) + 1 >= PROGRAM_SIZE) ? '0 : pc + 1'b1;
  always_comb begin
    case (k)
      OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_NOTEQ, OP_GT, OP_LES, OP_GE,
      OP_LE, OP_AND, OP_OR: is_bin = 1'b1;
      default: is_bin = 1'b0;
    endcase
  end

  // stack/precondition error, known at accept time from top, base and the operand only
  logic stk_err;
  always_comb begin
    case (k)
      OP_LOAD, OP_LOADI, OP_IN: stk_err = (top >= TW'(STACK_DEPTH));
      OP_STO, OP_BRF, OP_NOT, OP_OUT: stk_err = (top == '0);
      OP_RETURN: stk_err = (32'(base) + 1 >= STACK_DEPTH);
      OP_ENTER: stk_err = (ntop_s < 0) || (ntop_s > EW'(STACK_DEPTH));
      OP_CAL: stk_err = (32'(top) + 1 >= STACK_DEPTH);
      default: stk_err = is_bin && (top < TW'(2));
    endcase
  end

  // compute unit on a, b
  logic signed [WORD_WIDTH-1:0] sa, sb;
  logic [WORD_WIDTH-1:0] alu;
  assign sa = a;
  assign sb = b;
  always_comb begin
    case (k)
      OP_ADD:   alu = a + b;
      OP_SUB:   alu = a - b;
      OP_MULT:  alu = prod;
      OP_DIV:   alu = div_q;
      OP_EQ:    alu = WORD_WIDTH'(a == b);
      OP_NOTEQ: alu = WORD_WIDTH'(a != b);
      OP_GT:    alu = WORD_WIDTH'(sb < sa);
      OP_LES:   alu = WORD_WIDTH'(sa < sb);
      OP_GE:    alu = WORD_WIDTH'(!(sa < sb));
      OP_LE:    alu = WORD_WIDTH'(!(sb < sa));
      OP_AND:   alu = WORD_WIDTH'((a != '0) && (b != '0));
      OP_OR:    alu = WORD_WIDTH'((a != '0) || (b != '0));
      // not works on the top word
      default:  alu = WORD_WIDTH'(b == '0);
    endcase
  end

  // return checks on loaded words: a = saved base, b = return address
  logic ret_ok;
  assign ret_ok = !a[WORD_WIDTH-1] && ($unsigned(a) < WORD_WIDTH'(STACK_DEPTH)) &&
                  !b[WORD_WIDTH-1] && ($unsigned(b) < WORD_WIDTH'(PROGRAM_SIZE));

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (q_valid && !r_full) st_next = ST_RD1;
      ST_RD1:  st_next = halt ? ST_RSLT : ST_RD2;
      ST_RD2:  st_next = ST_OPND;
      ST_OPND: st_next = (k == OP_DIV && !stk_err && rword != '0) ? ST_DIV : ST_EXEC;
      ST_DIV:  if (div_done) st_next = ST_EXEC;
      ST_EXEC: st_next = (k == OP_CAL && !stk_err && tgt_ok) ? ST_WR2 : ST_RSLT;
      ST_WR2:  st_next = ST_RSLT;
      ST_RSLT: st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // ram read address per phase: first read at RD1 issue, second at RD2 issue
  always_comb begin
    raddr = '0;
    case (st)
      ST_IDLE: raddr = '0;
      ST_RD1: begin
        if (k == OP_RETURN) raddr = base;
        else if (is_bin) raddr = AW'(top - TW'(2));
        else raddr = AW'(addr_s);
      end
      default: begin
        if (k == OP_RETURN) raddr = AW'(base + 1'b1);
        else raddr = AW'(top - 1'b1);
      end
    endcase
  end

  // error and write decision in EXEC and WR2 (a, b hold operands)
  err_t            err;
  logic [PCW-1:0]  npc;
  logic            ov;
  logic [WORD_WIDTH-1:0] oval;
  always_comb begin
    err = ERR_NONE;
    npc = seq;
    ov = 1'b0;
    oval = '0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (stk_err) err = ERR_STACK;
    else begin
      case (k)
        OP_DIV: if (b == '0) err = ERR_DIV0;
        OP_LOAD, OP_STO: if (!addr_ok) err = ERR_ADDR;
        OP_BR: if (!tgt_ok) err = ERR_ADDR; else npc = PCW'(opnd);
        OP_BRF: if (b == '0) begin
          if (!tgt_ok) err = ERR_ADDR; else npc = PCW'(opnd);
        end
        OP_RETURN: if (!ret_ok) err = ERR_ADDR; else npc = PCW'(b);
        OP_CAL: if (!tgt_ok) err = ERR_ADDR; else npc = PCW'(opnd);
        OP_STOP: npc = pc;
        OP_OUT: begin ov = 1'b1; oval = b; end
        default: ;
      endcase
    end
    if (st == ST_EXEC && err == ERR_NONE) begin
      case (k)
        OP_LOAD:  begin we = 1'b1; waddr = AW'(top); wdata = a; end
        OP_LOADI: begin we = 1'b1; waddr = AW'(top); wdata = WORD_WIDTH'($signed(opnd)); end
        OP_IN:    begin we = 1'b1; waddr = AW'(top); wdata = WORD_WIDTH'($signed(inv)); end
        OP_STO:   begin we = 1'b1; waddr = AW'(addr_s); wdata = b; end
        OP_NOT:   begin we = 1'b1; waddr = AW'(top - 1'b1); wdata = alu; end
        OP_CAL:   begin we = 1'b1; waddr = AW'(top); wdata = WORD_WIDTH'(base); end
        default:  if (is_bin) begin we = 1'b1; waddr = AW'(top - TW'(2)); wdata = alu; end
      endcase
    end else if (st == ST_WR2) begin
      we = 1'b1;
      waddr = AW'(top + 1'b1);
      wdata = WORD_WIDTH'(seq_l);
    end
  end

  assign q_pop     = (st == ST_IDLE) && q_valid && !r_full;
  assign div_start = (st == ST_OPND) && (st_next == ST_DIV);
  assign m_tvalid  = r_full;
  assign m_tdata   = r_data;

  // state register
  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  // datapath and architectural updates
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0; base <= '0; pc <= '0; halt <= 1'b0; vld <= '0; r_full <= 1'b0;
    end else begin
      if (r_full && m_tready) r_full <= 1'b0;
      if (we) vld[waddr] <= 1'b1;
      if (q_pop) begin
        k <= opcode_t'(q_kind); opnd <= q_operand; inv <= q_in_value;
      end
      if (st == ST_EXEC) begin
        seq_l <= seq;
        if (err == ERR_NONE) begin
          case (k)
            OP_LOAD, OP_LOADI, OP_IN: top <= top + 1'b1;
            OP_STO, OP_BRF, OP_OUT: top <= top - 1'b1;
            OP_RETURN: begin top <= TW'(base); base <= AW'(a); end
            OP_ENTER: top <= TW'(ntop_s);
            OP_CAL: base <= AW'(top);
            default: if (is_bin) top <= top - 1'b1;
          endcase
        end
        pc   <= npc;
        halt <= (k == OP_STOP && err == ERR_NONE) || (npc == '0);
        r_data <= {2'd0, err, (k == OP_STOP && err == ERR_NONE) || (npc == '0),
                   OPND_W'($signed(oval)), ov, PC_W'(npc)};
      end
      if (st == ST_RD1 && halt) r_data <= {2'd0, ERR_NONE, 1'b1, {OPND_W{1'b0}}, 1'b0, PC_W'(pc)};
      if (st == ST_RSLT) r_full <= 1'b1;
    end
  end

  // a takes the first read, b the second one in the next cycle; product registered
  always_ff @(posedge clk) begin
    if (st == ST_RD2) a <= rword;
    if (st == ST_OPND) begin
      b    <= rword;
      prod <= a * rword;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_execute_unit.sv =====
// top level of the stack machine execute unit: front queue plus back executor
// depends on smeu_pkg, smeu_front, smeu_back
// One instruction is transferred on the s side and one result on the m side per
// instruction. With an always-ready sink the executor takes an instruction through
// a queue pop, two registered stack ram reads, an operand capture, the execute
// state with its stack write and result load, a state that marks the result valid
// and a state in which the result transfers before the next pop. CAL adds
// a state for its second stack write, DIV waits for the bit-serial divider, and a
// halted machine goes from its first read state straight to the result. A stalled
// result holds the executor while the two-entry queue still takes instructions.
// Stack entries read as zero until written (valid bits).
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int PROGRAM_SIZE = PROGRAM_SIZE_DEF,
  parameter int WORD_WIDTH   = WORD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // kind[4:0], operand[36:5], in_value[68:37]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // next_pc[9:0], out_valid[10], out_value[42:11],
                                     // halted[43], error_code[45:44]
);
  logic              q_valid, q_pop;
  logic [KIND_W-1:0] q_kind;
  logic [OPND_W-1:0] q_operand, q_in_value;

  // instruction queue
  smeu_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_valid, .q_pop, .q_kind, .q_operand, .q_in_value
  );

  // executor
  smeu_back #(
    .STACK_DEPTH(STACK_DEPTH), .PROGRAM_SIZE(PROGRAM_SIZE), .WORD_WIDTH(WORD_WIDTH)
  ) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_kind, .q_operand, .q_in_value,
    .m_tvalid, .m_tready, .m_tdata
  );
endmodule
`default_nettype wire

// ===== rtl/core/smeu_checker.sv =====
// port-level checker for the stack machine execute unit, bound to the top level
// depends on stack_machine_execute_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_unit_macros.svh"
module smeu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);
  // a result stalled by the sink holds its payload
  `SMEU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  // out_value is zero unless out_valid
  `SMEU_ASSERT(a_oval, !m_tvalid || m_tdata[10] || m_tdata[42:11] == 32'd0, "stray out value")
  // an error never comes with an out value
  `SMEU_ASSERT(a_err_ov, !m_tvalid || m_tdata[45:44] == 2'd0 || !m_tdata[10], "error with out")
  // a zero next pc always reports halt
  `SMEU_ASSERT(a_halt, !m_tvalid || m_tdata[9:0] != 10'd0 || m_tdata[43], "pc zero not halted")
endmodule
bind stack_machine_execute_unit smeu_checker u_smeu_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
